@@ sv/srld_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srld_pkg
// Shared types and constants of the S-record line decoder.
// ----------------------------------------------------------------------------
package srld_pkg;

	// Start addresses at or above this limit are rejected.
	localparam logic [24:0] ADDR_LIMIT = 25'd32768;

	localparam logic [7:0] CHAR_NL = 8'd10;
	localparam logic [7:0] CHAR_S  = 8'h53;
	localparam logic [7:0] CHAR_1  = 8'h31;
	localparam logic [7:0] CHAR_2  = 8'h32;
	localparam logic [7:0] CHAR_A  = 8'h41;

	localparam logic [5:0] ADDR_START   = 6'd4;
	localparam logic [5:0] DSTART_SHORT = 6'd8;
	localparam logic [5:0] DSTART_LONG  = 6'd10;
	localparam logic [5:0] DATA_DIGITS  = 6'd32;
	localparam logic [5:0] POS_MAX      = 6'd63;

	// Input kinds.
	localparam logic IN_CHAR = 1'b0;
	localparam logic IN_EOF  = 1'b1;

	// Result kinds.
	localparam logic [1:0] OUT_WRITE   = 2'd0;
	localparam logic [1:0] OUT_BAD     = 2'd1;
	localparam logic [1:0] OUT_SUMMARY = 2'd2;

	// Operations handed from the front to the back.
	typedef enum logic [1:0] {
		OP_ADDR,   // one address digit
		OP_HI,     // high nibble of a data byte
		OP_LO,     // low nibble, completes a byte write
		OP_EOF     // end of file
	} q_op_t;

	typedef struct packed {
		q_op_t      op;
		logic [3:0] nib;
		logic       first;   // first address digit of the line
		logic       last;    // last address digit, range check
	} q_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

@@ sv/srld_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srld_front
// Tracks line position and record type, turns characters into operations.
// ----------------------------------------------------------------------------
module srld_front import srld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       in_kind,
	input  logic [7:0] in_char,
	input  q_stat_t    q_stat,
	output logic       push,
	output q_entry_t   push_entry
);

	logic [5:0] pos_q;
	logic       long_q;
	logic       ignored_q;

	logic       acc;
	logic [5:0] dstart;
	logic [5:0] rel;
	logic [7:0] hex_off;
	logic [3:0] nib;

	assign in_ready = !q_stat.full;
	assign acc      = in_valid && in_ready;
	assign dstart   = long_q ? DSTART_LONG : DSTART_SHORT;
	assign rel      = pos_q - dstart;
	// letter: c - 'A' + 10, digit: c - '0', both kept mod 16
	assign hex_off  = in_char + 8'd9;
	assign nib      = (in_char >= CHAR_A) ? hex_off[3:0] : in_char[3:0];

	always_comb begin
		push             = 1'b0;
		push_entry.op    = OP_EOF;
		push_entry.nib   = nib;
		push_entry.first = (pos_q == ADDR_START);
		push_entry.last  = (pos_q == dstart - 6'd1);
		if (acc) begin
			if (in_kind == IN_EOF) begin
				push = 1'b1;
			end else if (in_char != CHAR_NL && !ignored_q && pos_q >= ADDR_START) begin
				if (pos_q < dstart) begin
					push          = 1'b1;
					push_entry.op = OP_ADDR;
				end else if (pos_q < dstart + DATA_DIGITS) begin
					push          = 1'b1;
					push_entry.op = rel[0] ? OP_LO : OP_HI;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			long_q    <= 1'b0;
			ignored_q <= 1'b0;
		end else if (acc) begin
			if (in_kind == IN_EOF || in_char == CHAR_NL) begin
				pos_q     <= '0;
				long_q    <= 1'b0;
				ignored_q <= 1'b0;
			end else begin
				if (pos_q != POS_MAX)
					pos_q <= pos_q + 6'd1;
				if (!ignored_q) begin
					if (pos_q == 6'd0) begin
						if (in_char != CHAR_S)
							ignored_q <= 1'b1;
					end else if (pos_q == 6'd1) begin
						if (in_char == CHAR_1)
							long_q <= 1'b0;
						else if (in_char == CHAR_2)
							long_q <= 1'b1;
						else
							ignored_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

@@ sv/srld_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srld_queue
// Two-entry queue of operations between the front and the back.
// ----------------------------------------------------------------------------
module srld_queue import srld_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	input  logic     pop,
	output q_entry_t pop_entry,
	output q_stat_t  q_stat
);

	q_entry_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign q_stat.empty = (count_q == 2'd0);
	assign q_stat.full  = (count_q == 2'd2);
	assign pop_entry    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

@@ sv/srld_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srld_back
// Builds addresses, emits byte writes, range errors and end-of-file summaries.
// ----------------------------------------------------------------------------
module srld_back import srld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  q_stat_t     q_stat,
	input  q_entry_t    op_entry,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_kind,
	output logic [63:0] out_data
);

	logic [23:0] addr_q;
	logic [3:0]  hi_q;
	logic [15:0] high_end_q;
	logic        stopped_q;
	logic        valid_q;
	logic [1:0]  kind_q;
	logic [63:0] data_q;

	logic [23:0] addr_next;
	logic [23:0] addr_inc;
	logic [15:0] end_addr;
	logic        range_bad;

	assign pop       = !q_stat.empty && (!valid_q || out_ready);
	assign addr_next = op_entry.first ? {20'd0, op_entry.nib} : {addr_q[19:0], op_entry.nib};
	assign range_bad = op_entry.last && ({1'b0, addr_next} >= ADDR_LIMIT);
	assign addr_inc  = addr_q + 24'd1;
	// end address saturates at 16 bits, including the wrap to zero
	assign end_addr  = (addr_inc == 24'd0 || addr_inc[23:16] != 8'd0) ? 16'hFFFF
		: addr_inc[15:0];

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q     <= '0;
			hi_q       <= '0;
			high_end_q <= '0;
			stopped_q  <= 1'b0;
			valid_q    <= 1'b0;
			kind_q     <= OUT_WRITE;
			data_q     <= '0;
		end else begin
			if (out_ready)
				valid_q <= 1'b0;
			if (pop) begin
				if (op_entry.op == OP_EOF) begin
					valid_q    <= 1'b1;
					kind_q     <= OUT_SUMMARY;
					data_q     <= {high_end_q, 48'd0};
					addr_q     <= '0;
					hi_q       <= '0;
					high_end_q <= '0;
					stopped_q  <= 1'b0;
				end else if (!stopped_q) begin
					case (op_entry.op)
						OP_ADDR: begin
							addr_q <= addr_next;
							if (range_bad) begin
								valid_q   <= 1'b1;
								kind_q    <= OUT_BAD;
								data_q    <= {16'd0, addr_next, 24'd0};
								stopped_q <= 1'b1;
							end
						end
						OP_HI: begin
							hi_q <= op_entry.nib;
						end
						OP_LO: begin
							valid_q <= 1'b1;
							kind_q  <= OUT_WRITE;
							data_q  <= {40'd0, hi_q, op_entry.nib, addr_q[15:0]};
							addr_q  <= addr_inc;
							if (end_addr > high_end_q)
								high_end_q <= end_addr;
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

endmodule

@@ sv/srecord_line_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srecord_line_decoder
// S-record text decoder: one character per beat in, byte writes out.
// ----------------------------------------------------------------------------
// Takes one character per clock, sustained, as long as the result side keeps
// up. A front stage tracks the line position and record type (S1 or S2) and
// turns each character into an operation; a two-entry queue hands those to a
// back stage that builds the address, pairs data nibbles into bytes and keeps
// the highest end address. Each operation is registered in the queue and each
// result is held in an output register; while a result waits the queue
// takes up to two more operations before the input stalls. Throughput is
// bounded by the one queue pop per clock in the back stage. Only the first 32
// data digits of a record are written; byte count and checksum are not
// checked. A start address at or above 32768 gives one error beat and silences
// the file until end of file, which always gives a summary beat and clears all
// state.
// ----------------------------------------------------------------------------
module srecord_line_decoder import srld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] char_code
	input  logic        s_tuser,    // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,    // [15:0] write_address, [23:16] write_byte,
	                                // [47:24] bad_address, [63:48] rom_length
	output logic [1:0]  m_tuser     // [1:0] out_kind
);

	q_stat_t  q_stat;
	q_entry_t push_entry;
	q_entry_t pop_entry;
	logic     push;
	logic     pop;

	// Front: line parsing and classification of each character beat.
	srld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_kind    (s_tuser),
		.in_char    (s_tdata),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// Decouples the front from output back-pressure.
	srld_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.q_stat     (q_stat)
	);

	// Back: address arithmetic and result register.
	srld_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.op_entry   (pop_entry),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (m_tuser),
		.out_data   (m_tdata)
	);

	// Never pop an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	// Never push into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_stat.full)
		else $error("queue pushed while full");

	// Result kind is one of the three defined codes.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == OUT_WRITE || m_tuser == OUT_BAD || m_tuser == OUT_SUMMARY))
		else $error("undefined result kind");

	// On write and summary beats, fields that do not belong to the result kind are zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == OUT_WRITE) |-> (m_tdata[63:24] == 40'd0))
		else $error("write beat carries stray fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == OUT_SUMMARY) |-> (m_tdata[47:0] == 48'd0))
		else $error("summary beat carries stray fields");

endmodule

@@ dv/srecord_line_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srecord_line_decoder_tb
// Self-checking bench for the S-record line decoder.
// ----------------------------------------------------------------------------
// Streams S-record text into the decoder one character per beat. A queue of
// beats is filled up front: a short directed file first, then random records.
// Most random records are well formed S1/S2 lines with random data. The rest
// are cut short, carry bad addresses, carry noise, or are end-of-file marks.
// A clocked driver feeds the beats with random gaps. The receiver stalls at
// random. Both go steady for the last part of the run. Every accepted
// character runs through a local decoder model, and each result beat is
// compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module srecord_line_decoder_tb;
	import srld_pkg::*;

	localparam logic [7:0] DIGIT_0    = 8'h30;
	localparam logic [7:0] LOWER_A    = 8'h61;
	localparam int         QUIET_TAIL = 150;   // beats left when idling stops
	localparam int         RAND_BEATS = 1350;

	typedef struct packed {
		logic       kind;
		logic [7:0] ch;
	} text_beat_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [15:0] write_address;
		logic [7:0]  write_byte;
		logic [23:0] bad_address;
		logic [15:0] rom_length;
	} dec_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [7:0] char_code
	logic        s_tuser;    // [0] kind
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;    // [15:0] write_address, [23:16] write_byte,
	                         // [47:24] bad_address, [63:48] rom_length
	logic [1:0]  m_tuser;    // [1:0] out_kind

	text_beat_t  text_beats[$];
	dec_result_t pending_results[$];
	int          error_count;
	int          src_gap;
	int          sink_gap;

	// decoder model state
	logic [5:0]  line_pos;
	logic        is_s2;
	logic [23:0] addr_acc;
	logic [3:0]  hi_nib;
	logic [15:0] top_end;
	logic        halted;
	logic        skip_line;

	srecord_line_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Decoder model
	// ------------------------------------------------------------------
	// Any character maps to a nibble: the hex formula taken mod 16.
	function automatic logic [3:0] nibble_of(input logic [7:0] ch);
		logic [7:0] v;
		if (ch >= CHAR_A) begin
			v = ch - CHAR_A + 8'd10;
		end else begin
			v = ch - DIGIT_0;
		end
		return v[3:0];
	endfunction

	task automatic clear_line();
		line_pos  = '0;
		is_s2     = 1'b0;
		addr_acc  = '0;
		hi_nib    = '0;
		skip_line = 1'b0;
	endtask

	task automatic decode_char(input logic kind, input logic [7:0] ch);
		dec_result_t r;
		logic [5:0]  pos;
		logic [5:0]  dstart;
		logic [5:0]  dpos;
		logic [3:0]  nib;
		logic [15:0] end_addr;
		r = '0;
		if (kind == IN_EOF) begin
			// summary even while halted, then a full clear
			r.out_kind   = OUT_SUMMARY;
			r.rom_length = top_end;
			pending_results.push_back(r);
			clear_line();
			top_end = '0;
			halted  = 1'b0;
		end else if (!halted) begin
			if (ch == CHAR_NL) begin
				clear_line();
			end else begin
				pos = line_pos;
				if (line_pos < POS_MAX)
					line_pos = line_pos + 6'd1;
				dstart = is_s2 ? DSTART_LONG : DSTART_SHORT;
				nib    = nibble_of(ch);
				dpos   = pos - dstart;
				if (skip_line) begin
					// rest of a non-record line
				end else if (pos == 6'd0) begin
					if (ch != CHAR_S)
						skip_line = 1'b1;
				end else if (pos == 6'd1) begin
					if (ch == CHAR_1)
						is_s2 = 1'b0;
					else if (ch == CHAR_2)
						is_s2 = 1'b1;
					else
						skip_line = 1'b1;
				end else if (pos < ADDR_START) begin
					// byte count digits are not used
				end else if (pos < dstart) begin
					addr_acc = {addr_acc[19:0], nib};
					if (pos == dstart - 6'd1 && {1'b0, addr_acc} >= ADDR_LIMIT) begin
						r.out_kind    = OUT_BAD;
						r.bad_address = addr_acc;
						pending_results.push_back(r);
						halted = 1'b1;
					end
				end else if (pos < dstart + DATA_DIGITS) begin
					if (!dpos[0]) begin
						hi_nib = nib;
					end else begin
						r.out_kind      = OUT_WRITE;
						r.write_address = addr_acc[15:0];
						r.write_byte    = {hi_nib, nib};
						pending_results.push_back(r);
						addr_acc = addr_acc + 24'd1;
						// end address saturates at 16 bits; a wrap to 0 counts as top
						if (addr_acc == '0 || addr_acc > 24'hFFFF)
							end_addr = 16'hFFFF;
						else
							end_addr = addr_acc[15:0];
						if (end_addr > top_end)
							top_end = end_addr;
					end
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
		if (v < 4'd10)
			return DIGIT_0 + 8'(v);
		return (lower ? LOWER_A : CHAR_A) + 8'(v) - 8'd10;
	endfunction

	function automatic logic [7:0] noise_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (c == CHAR_NL)
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	task automatic push_char(input logic [7:0] ch);
		text_beats.push_back('{kind: IN_CHAR, ch: ch});
	endtask

	task automatic push_eof(input logic [7:0] ch);
		text_beats.push_back('{kind: IN_EOF, ch: ch});
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
	endtask

	// One record line: type, byte count, address, 32 data digits, checksum and
	// tail_len trailing characters. cut_at >= 0 cuts the line to that many
	// characters. mangle_pct of the data digits are lowercase or any character.
	task automatic add_record(input bit long_rec, input logic [23:0] start,
	                          input int cut_at, input int tail_len, input int mangle_pct);
		logic [7:0] line[$];
		int         n_addr;
		line.push_back(CHAR_S);
		line.push_back(long_rec ? CHAR_2 : CHAR_1);
		repeat (2) line.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
		n_addr = long_rec ? 6 : 4;
		for (int i = n_addr - 1; i >= 0; i--)
			line.push_back(hex_char(4'(start >> (4 * i)), 1'b0));
		for (int i = 0; i < 2 * 16; i++) begin
			if ($urandom_range(0, 99) < mangle_pct)
				line.push_back($urandom_range(0, 1) ? noise_char() :
				               hex_char(4'($urandom_range(0, 15)), 1'b1));
			else
				line.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
		end
		repeat (2) line.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
		repeat (tail_len) line.push_back(noise_char());
		if (cut_at >= 0)
			while (line.size() > cut_at)
				void'(line.pop_back());
		foreach (line[i])
			push_char(line[i]);
		push_char(CHAR_NL);
	endtask

	function automatic logic [23:0] good_start();
		if ($urandom_range(0, 3) == 0)
			return 24'($urandom_range(32'h7FE0, 32'h7FFF));   // writes may run past the limit
		return 24'($urandom_range(0, 32'h7FFF));
	endfunction

	function automatic logic [23:0] bad_start(input bit long_rec);
		if ($urandom_range(0, 1))
			return 24'($urandom_range(32'h8000, 32'h8010));
		return 24'($urandom_range(32'h8000, long_rec ? 32'hFF_FFFF : 32'hFFFF));
	endfunction

	task automatic build_random();
		int r;
		bit lr;
		while (text_beats.size() < RAND_BEATS) begin
			r  = $urandom_range(0, 99);
			lr = $urandom_range(0, 1);
			if (r < 68) begin
				add_record(lr, good_start(), -1, $urandom_range(0, 3) == 0 ?
				           $urandom_range(1, 30) : 0, $urandom_range(0, 1) ? 0 : 15);
			end else if (r < 78) begin
				add_record(lr, good_start(), $urandom_range(0, 45), 0, 10);
			end else if (r < 84) begin
				// bad start, then text the block must drop until end of file
				add_record(lr, bad_start(lr), -1, 0, 0);
				if ($urandom_range(0, 1))
					add_record(~lr, good_start(), -1, 0, 0);
				repeat ($urandom_range(0, 6)) push_char(8'($urandom_range(0, 255)));
				push_eof(8'($urandom_range(0, 255)));
			end else if (r < 90) begin
				repeat ($urandom_range(1, 20)) push_char(8'($urandom_range(0, 255)));
				push_char(CHAR_NL);
			end else if (r < 95) begin
				push_eof(8'($urandom_range(0, 255)));
			end else begin
				if (lr)
					push_text("S3");
				push_char(CHAR_NL);
			end
		end
		push_eof(8'h00);
	endtask

	// ------------------------------------------------------------------
	// Driver: one text beat per handshake, random gaps until the tail
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		text_beat_t b;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
			src_gap  <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (src_gap > 0) begin
				src_gap  <= src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (text_beats.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (text_beats.size() > QUIET_TAIL && $urandom_range(0, 15) == 0) begin
				src_gap  <= $urandom_range(0, 12);
				s_tvalid <= 1'b0;
			end else begin
				b = text_beats.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= b.ch;
				s_tuser  <= b.kind;
			end
		end
	end

	// Receiver stalls in random bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap <= 0;
		end else if (sink_gap > 0) begin
			sink_gap <= sink_gap - 1;
			m_tready <= 1'b0;
		end else if (text_beats.size() > QUIET_TAIL && $urandom_range(0, 11) == 0) begin
			sink_gap <= $urandom_range(0, 12);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predict on input beats, compare on result beats
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [23:0] want,
	                           input logic [23:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		dec_result_t w;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				decode_char(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("out_kind: expected no beat, got %0d", m_tuser);
					error_count++;
				end else begin
					w = pending_results.pop_front();
					check_field("out_kind",      24'(w.out_kind),      24'(m_tuser));
					check_field("write_address", 24'(w.write_address), 24'(m_tdata[15:0]));
					check_field("write_byte",    24'(w.write_byte),    24'(m_tdata[23:16]));
					check_field("bad_address",   w.bad_address,        m_tdata[47:24]);
					check_field("rom_length",    24'(w.rom_length),    24'(m_tdata[63:48]));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		error_count = 0;
		clear_line();
		top_end = '0;
		halted  = 1'b0;
		arst_n  = 1'b0;

		// directed file
		push_eof(8'hFF);                              // empty file summary
		add_record(1'b0, 24'h0000, -1, 0, 0);
		push_text("S1130010");                        // odd digits, then cut in data
		push_text("0F9AafG~");
		push_char(8'hFF);
		push_char(8'h80);
		push_char(8'h00);
		push_char(CHAR_NL);
		add_record(1'b1, 24'h007FF8, -1, 25, 0);     // crosses the limit, long tail
		push_text("S30500001234");
		push_char(CHAR_NL);
		push_text("X1130000AA");
		push_char(CHAR_NL);
		push_text("S9");
		push_char(CHAR_NL);
		push_char(CHAR_NL);
		push_text("S1137F");                          // cut in address digits
		push_char(CHAR_NL);
		add_record(1'b0, 24'h7FFF, -1, 0, 0);
		push_eof(CHAR_S);
		add_record(1'b0, 24'h8000, -1, 0, 0);        // exactly at the limit
		add_record(1'b0, 24'h0100, -1, 0, 0);        // dropped while halted
		push_eof(8'h7F);
		add_record(1'b1, 24'hFFFFFF, -1, 0, 0);
		push_text("S1");
		push_eof(8'h00);

		build_random();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (text_beats.size() != 0 || s_tvalid)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (error_count == 0)
			$display("srecord_line_decoder_tb: done, clean");
		else
			$display("srecord_line_decoder_tb: done, errors");
		$finish;
	end

	initial begin
		#8000000;
		$display("srecord_line_decoder_tb: done, errors");
		$finish;
	end

endmodule
